### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/sxsg_pkg.sv
// ----------------------------------------------------------------------------
// sxsg_pkg
// Types, constants and helpers for the xorshift64* byte generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sxsg_pkg;

	localparam int COUNT_W = 7;
	localparam int WORD_W  = 64;
	localparam int HALF_W  = 32;
	localparam int BYTE_W  = 8;

	localparam logic [COUNT_W-1:0] MAX_REQUEST_BYTES = 7'd64;

	localparam logic [WORD_W-1:0] GOLDEN_SEED = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] STAR_MULT   = 64'd2685821657736338717;

	localparam int SHIFT_A = 12;
	localparam int SHIFT_B = 25;
	localparam int SHIFT_C = 27;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MIX,
		ST_MUL,
		ST_SUM,
		ST_EMIT
	} sxsg_state_t;

	typedef struct packed {
		logic accept;
		logic load_seed;
		logic mix;
		logic mul;
		logic sum;
		logic pos_inc;
	} sxsg_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic lane_last;
		logic last_byte;
	} sxsg_status_t;

	function automatic logic [WORD_W-1:0] xs_shift(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] t;
		t = v ^ (v >> SHIFT_A);
		t = t ^ (t << SHIFT_B);
		t = t ^ (t >> SHIFT_C);
		return t;
	endfunction

endpackage

### rtl/core/seeded_xorshift_star_byte_generator_top.sv
// ----------------------------------------------------------------------------
// seeded_xorshift_star_byte_generator_top
// Seeded xorshift64* random byte generator with a streaming request input
// and a streaming byte output.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave channel: one transaction carries a byte count (0..127, saturated
//    to 64). The channel is ready only while no request is in progress.
//  - Master channel: one transaction per generated byte, LSB of each state
//    word first; tlast marks the final byte of the request. A zero count
//    produces no output transaction.
//  - seed_value is written when seed_value_we is high; write only while idle.
//    A zero seed selects the golden constant.
//  - Each 8-byte word passes the mix (xorshift, split multiply,
//    partial-product sum) before its first byte, then one byte per cycle
//    while the master channel is ready.
//  - Reset clears the seed and the generator state; the first request after
//    reset loads the state from the seed.
//  - A stalled master channel holds the current byte and tlast; the block
//    waits and loses nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module seeded_xorshift_star_byte_generator_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       seed_value_we,
	input  logic [sxsg_pkg::WORD_W-1:0] seed_value,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [6:0] byte_count, [7] zero
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,   // [7:0] random_byte
	output logic                       m_tlast    // last_byte
);
	import sxsg_pkg::*;

	sxsg_cmd_t    cmd;
	sxsg_status_t status;

	sxsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sxsg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.seed_value_we (seed_value_we),
		.seed_value    (seed_value),
		.byte_count    (s_tdata[COUNT_W-1:0]),
		.cmd           (cmd),
		.status        (status),
		.random_byte   (m_tdata)
	);

	assign m_tlast = status.last_byte;

	`ASSERT_IMPL(a_no_overlap, clk, arst_n, m_tvalid, !s_tready)
	`ASSERT_NEXT(a_last_to_idle, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready)
	`ASSERT_NEXT(a_word_emits, clk, arst_n, cmd.sum, m_tvalid)

endmodule

### rtl/core/sxsg_ctrl.sv
// ----------------------------------------------------------------------------
// sxsg_ctrl
// Sequencer: request intake, seed load, three-step mix, byte emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sxsg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  sxsg_pkg::sxsg_status_t status,
	output sxsg_pkg::sxsg_cmd_t    cmd
);
	import sxsg_pkg::*;

	sxsg_state_t state_q;
	sxsg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = status.count_zero ? ST_IDLE : ST_MIX;
			end
			ST_MIX:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (m_tready) begin
					if (status.last_byte) begin
						state_d = ST_IDLE;
					end else if (status.lane_last) begin
						state_d = ST_MIX;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		m_tvalid      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_LOAD: cmd.load_seed = 1'b1;
			ST_MIX:  cmd.mix = 1'b1;
			ST_MUL:  cmd.mul = 1'b1;
			ST_SUM:  cmd.sum = 1'b1;
			ST_EMIT: begin
				m_tvalid    = 1'b1;
				cmd.pos_inc = m_tready;
			end
			default: ;
		endcase
	end

endmodule

### rtl/core/sxsg_dp.sv
// ----------------------------------------------------------------------------
// sxsg_dp
// Datapath: seed register, generator state, xorshift, split 64-bit multiply,
// byte counter and output byte select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sxsg_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       seed_value_we,
	input  logic [sxsg_pkg::WORD_W-1:0] seed_value,
	input  logic [sxsg_pkg::COUNT_W-1:0] byte_count,
	input  sxsg_pkg::sxsg_cmd_t         cmd,
	output sxsg_pkg::sxsg_status_t      status,
	output logic [sxsg_pkg::BYTE_W-1:0]  random_byte
);
	import sxsg_pkg::*;

	logic [WORD_W-1:0]  seed_q;
	logic [WORD_W-1:0]  mix_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] pos_q;
	logic [WORD_W-1:0]  eff_seed;
	logic [WORD_W-1:0]  v_s1;
	logic [WORD_W-1:0]  p_ll_s2;
	logic [HALF_W-1:0]  p_lh_s2;
	logic [HALF_W-1:0]  p_hl_s2;
	logic [WORD_W-1:0]  prod_ll;
	logic [HALF_W-1:0]  prod_lh;
	logic [HALF_W-1:0]  prod_hl;
	logic [COUNT_W-1:0] pos_next;

	assign eff_seed = (seed_q == '0) ? GOLDEN_SEED : seed_q;
	assign pos_next = pos_q + COUNT_W'(1);

	assign prod_ll = v_s1[HALF_W-1:0] * STAR_MULT[HALF_W-1:0];
	assign prod_lh = HALF_W'(v_s1[HALF_W-1:0] * STAR_MULT[WORD_W-1:HALF_W]);
	assign prod_hl = HALF_W'(v_s1[WORD_W-1:HALF_W] * STAR_MULT[HALF_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			mix_q   <= '0;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			if (seed_value_we) seed_q <= seed_value;
			if (cmd.accept) begin
				count_q <= (byte_count > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : byte_count;
				pos_q   <= '0;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_next;
			end
			if (cmd.load_seed && (mix_q == '0)) begin
				mix_q <= eff_seed;
			end else if (cmd.sum) begin
				mix_q <= p_ll_s2 + {p_lh_s2 + p_hl_s2, {HALF_W{1'b0}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mix) begin
			v_s1 <= xs_shift(mix_q ^ eff_seed ^ WORD_W'(pos_q));
		end
		if (cmd.mul) begin
			p_ll_s2 <= prod_ll;
			p_lh_s2 <= prod_lh;
			p_hl_s2 <= prod_hl;
		end
	end

	assign status.count_zero = (count_q == '0);
	assign status.lane_last  = (pos_q[2:0] == 3'd7);
	assign status.last_byte  = (pos_next == count_q);
	assign random_byte       = mix_q[{pos_q[2:0], 3'b000} +: BYTE_W];

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the seeded xorshift64* byte generator. Requests go
// in on the slave stream, generated bytes come out on the master stream and
// are matched in order against a local model of the generator. A directed
// table covers zero, small, word-edge and oversized counts and the seed
// extremes. Random phases follow, each under a new seed, with random gaps
// on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import sxsg_pkg::WORD_W;
	import sxsg_pkg::COUNT_W;
	import sxsg_pkg::BYTE_W;

	localparam logic [WORD_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] SCRAMBLE_MULT = 64'd2685821657736338717;
	localparam int BURST_LIMIT = 64;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER = 300;
	localparam int PHASES = 6;
	localparam int REQS_PER_PHASE = 32;

	typedef enum logic {
		ROW_REQ,
		ROW_SEED
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [WORD_W-1:0] seed;
		logic [COUNT_W-1:0] count;
		logic              zero_head;  // first word of bytes known to be zero
	} stim_row_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} byte_xact_t;

	// a fresh load gives state ^ seed ^ 0 == 0, so the first word mixes to zero
	stim_row_t directed_rows [22] = '{
		'{ROW_REQ,  64'd0, 7'd1,   1'b1},
		'{ROW_REQ,  64'd0, 7'd0,   1'b0},
		'{ROW_REQ,  64'd0, 7'd8,   1'b1},
		'{ROW_REQ,  64'd0, 7'd9,   1'b1},
		'{ROW_REQ,  64'd0, 7'd127, 1'b0},
		'{ROW_REQ,  64'd0, 7'd65,  1'b0},
		'{ROW_REQ,  64'd0, 7'd64,  1'b0},
		'{ROW_SEED, 64'hffff_ffff_ffff_ffff, 7'd0, 1'b0},
		'{ROW_REQ,  64'd0, 7'd16,  1'b0},
		'{ROW_SEED, 64'h0000_0000_0000_0001, 7'd0, 1'b0},
		'{ROW_REQ,  64'd0, 7'd7,   1'b0},
		'{ROW_SEED, 64'd0, 7'd0,   1'b0},
		'{ROW_REQ,  64'd0, 7'd63,  1'b0},
		'{ROW_REQ,  64'd0, 7'd2,   1'b0},
		'{ROW_SEED, 64'h8000_0000_0000_0000, 7'd0, 1'b0},
		'{ROW_REQ,  64'd0, 7'd100, 1'b0},
		'{ROW_REQ,  64'd0, 7'd0,   1'b0},
		'{ROW_REQ,  64'd0, 7'd3,   1'b0},
		'{ROW_REQ,  64'd0, 7'd1,   1'b0},
		'{ROW_SEED, 64'h5555_5555_aaaa_aaaa, 7'd0, 1'b0},
		'{ROW_REQ,  64'd0, 7'd64,  1'b0},
		'{ROW_REQ,  64'd0, 7'd40,  1'b0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               seed_value_we = 1'b0;
	logic [WORD_W-1:0]  seed_value = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;    // [6:0] byte_count, [7] zero
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [7:0]         m_tdata;         // [7:0] random_byte
	logic               m_tlast;         // last_byte

	logic [WORD_W-1:0]  seed_reg = '0;
	logic [WORD_W-1:0]  gen_state = '0;
	byte_xact_t         pending_bytes[$];
	int                 mismatches = 0;
	int                 bytes_seen = 0;
	bit                 hold_off_done = 1'b0;

	seeded_xorshift_star_byte_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.seed_value_we (seed_value_we),
		.seed_value    (seed_value),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] star_scramble(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] t;
		t = v ^ (v >> 12);
		t = t ^ (t << 25);
		t = t ^ (t >> 27);
		return t * SCRAMBLE_MULT;
	endfunction

	function automatic void predict_burst(input logic [COUNT_W-1:0] count,
			input logic zero_head);
		logic [WORD_W-1:0] eff_seed;
		int n;
		byte_xact_t x;
		eff_seed = (seed_reg != '0) ? seed_reg : GOLDEN;
		n = (count > BURST_LIMIT) ? BURST_LIMIT : int'(count);
		if (gen_state == '0)
			gen_state = eff_seed;
		for (int pos = 0; pos < n; pos++) begin
			if (pos % 8 == 0)
				gen_state = star_scramble(gen_state ^ eff_seed ^ WORD_W'(pos));
			x.data = gen_state[8*(pos%8) +: 8];
			if (zero_head && pos < 8)
				x.data = 8'h00;
			x.last = (pos == n - 1);
			pending_bytes.push_back(x);
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic issue_request(input logic [COUNT_W-1:0] count, input logic zero_head);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, count};
		do @(posedge clk); while (!s_tready);
		predict_burst(count, zero_head);
	endtask

	task automatic load_seed(input logic [WORD_W-1:0] v);
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		seed_value_we <= 1'b1;
		seed_value <= v;
		@(posedge clk);
		seed_reg = v;
		seed_value_we <= 1'b0;
	endtask

	function automatic logic [COUNT_W-1:0] random_count();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return '0;
		else if (pick < 25)
			return COUNT_W'($urandom_range(1, 8));
		else if (pick < 85)
			return COUNT_W'($urandom_range(1, 64));
		else
			return COUNT_W'($urandom_range(65, 127));
	endfunction

	function automatic logic [WORD_W-1:0] random_seed();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		else
			return {$urandom, $urandom};
	endfunction

	// output acceptance
	always @(posedge clk) begin
		byte_xact_t want;
		if (arst_n && m_tvalid && m_tready) begin
			bytes_seen++;
			if (pending_bytes.size() == 0) begin
				report_mismatch("unexpected byte", m_tdata, 0);
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== want.data)
					report_mismatch("random_byte", m_tdata, want.data);
				if (m_tlast !== want.last)
					report_mismatch("last_byte", m_tlast, want.last);
			end
		end
	end

	// output ready pattern
	initial begin
		int stall_left;
		int mode_left;
		bit no_idle;
		stall_left = 0;
		mode_left = 0;
		no_idle = 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				no_idle = ($urandom_range(0, 9) < 3);
				mode_left = $urandom_range(50, 150);
			end
			mode_left--;
			if (!hold_off_done && bytes_seen >= HOLD_OFF_AFTER) begin
				hold_off_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 99) < 85)
					stall_left = $urandom_range(0, 2);
				else
					stall_left = $urandom_range(9, 39);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#40ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SEED)
				load_seed(directed_rows[i].seed);
			else
				issue_request(directed_rows[i].count, directed_rows[i].zero_head);
		end

		for (int p = 0; p < PHASES; p++) begin
			load_seed(random_seed());
			repeat (REQS_PER_PHASE) issue_request(random_count(), 1'b0);
		end

		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
